### rtl/core/earot_pkg.sv
// ----------------------------------------------------------------------------
// earot_pkg
// shared widths, types and arithmetic helpers of the euler angle rotator
// ----------------------------------------------------------------------------
package earot_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int TRIG_ITERATIONS = 16;

    localparam int BAM_WIDTH   = 32;
    localparam int CW          = 34;
    localparam int PROD_W      = 2 * CW;
    localparam int ENTRY_W     = 32;
    localparam int TERM_W      = ENTRY_W + COORD_WIDTH;
    localparam int ACC_W       = TERM_W + 2;
    localparam int OUT_W       = ACC_W - 30;
    localparam int SHIFT_W     = $clog2(TRIG_ITERATIONS);
    localparam int MATRIX_LAT  = 5;
    localparam int PIPE_LAT    = 1 + TRIG_ITERATIONS + MATRIX_LAT;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = ANGLE_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_ROLL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 2'd3;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_Q30     = CW'(1073741824);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [CW-1:0]          cval_t;
    typedef logic signed [ENTRY_W-1:0]     entry_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
    } rot_t;

    typedef struct packed {
        rot_t [2:0] rot;
        logic [2:0] neg;
        coord_t     cx;
        coord_t     cy;
        coord_t     cz;
        logic       inv;
    } cordic_beat_t;

    function automatic logic [BAM_WIDTH-1:0] atan_value(input logic [4:0] idx);
        logic [BAM_WIDTH-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic cval_t mul30(input cval_t a, input cval_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        p = p + PROD_W'(536870912);
        return CW'(p >>> 30);
    endfunction

    function automatic entry_t clamp1(input cval_t v);
        cval_t c;
        c = v;
        if (v > ONE_Q30)
            c = ONE_Q30;
        if (v < -ONE_Q30)
            c = -ONE_Q30;
        return ENTRY_W'(c);
    endfunction

endpackage

### rtl/core/earot_if.sv
// ----------------------------------------------------------------------------
// earot_if
// point and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface earot_point_if;
    import earot_pkg::*;
    logic   valid;
    logic   ready;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface earot_result_if;
    import earot_pkg::*;
    logic   valid;
    logic   ready;
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
    logic   saturated;
    modport source (output valid, output rot_x, output rot_y, output rot_z,
                    output saturated, input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                    input saturated, output ready);
endinterface

### rtl/core/euler_angle_point_rotation.sv
// ----------------------------------------------------------------------------
// euler_angle_point_rotation
// rotates a stream of q12.12 points by z-y-x euler angles, forward or inverse
// ----------------------------------------------------------------------------
// Takes one point per cycle and returns each rotated point through one input
// stage, a chain of 16 cordic cells and five matrix stages. The angles are
// sampled with each point at entry, so configuration written while the block
// is empty applies to the very next beat. A stalled result holds the whole
// pipeline; otherwise a new point is taken every cycle.
module euler_angle_point_rotation
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [earot_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [earot_pkg::CFG_DATA_W-1:0]  cfg_data,
    earot_point_if.sink                       points,
    earot_result_if.source                    results
);
    import earot_pkg::*;

    angle_t roll_reg, pitch_reg, yaw_reg;
    logic   inverse_reg;

    logic [PIPE_LAT-1:0] valid_reg;
    logic [PIPE_LAT-1:0] valid_next;
    logic                en;

    cordic_beat_t entry_next;
    cordic_beat_t entry_reg;
    cordic_beat_t chain [TRIG_ITERATIONS+1];
    angle_t       ang [3];
    logic [BAM_WIDTH-1:0] t [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            inverse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROLL:    roll_reg    <= cfg_data[ANGLE_WIDTH-1:0];
                REG_PITCH:   pitch_reg   <= cfg_data[ANGLE_WIDTH-1:0];
                REG_YAW:     yaw_reg     <= cfg_data[ANGLE_WIDTH-1:0];
                REG_INVERSE: inverse_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign en = !valid_reg[PIPE_LAT-1] || results.ready;
    assign points.ready = en;

    always_comb
    begin
        valid_next = {valid_reg[PIPE_LAT-2:0], points.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // quadrant fold, then cordic seed per angle
    always_comb
    begin
        ang[0] = roll_reg;
        ang[1] = pitch_reg;
        ang[2] = yaw_reg;
        entry_next.cx  = points.coord_x;
        entry_next.cy  = points.coord_y;
        entry_next.cz  = points.coord_z;
        entry_next.inv = inverse_reg;
        for (int k = 0; k < 3; k++)
        begin
            t[k] = {ang[k], {(BAM_WIDTH-ANGLE_WIDTH){1'b0}}};
            entry_next.neg[k] = t[k][BAM_WIDTH-1] ^ t[k][BAM_WIDTH-2];
            if (entry_next.neg[k])
                t[k][BAM_WIDTH-1] = ~t[k][BAM_WIDTH-1];
            entry_next.rot[k].x = CORDIC_GAIN;
            entry_next.rot[k].y = '0;
            entry_next.rot[k].z = CW'($signed(t[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            entry_reg <= entry_next;
    end

    assign chain[0] = entry_reg;

    for (genvar g = 0; g < TRIG_ITERATIONS; g++)
    begin : g_cell
        earot_cell u_cell
        (
            .clk   (clk),
            .en    (en),
            .stage (SHIFT_W'(g)),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    earot_matrix u_matrix
    (
        .clk       (clk),
        .en        (en),
        .din       (chain[TRIG_ITERATIONS]),
        .rot_x     (results.rot_x),
        .rot_y     (results.rot_y),
        .rot_z     (results.rot_z),
        .saturated (results.saturated)
    );

    assign results.valid = valid_reg[PIPE_LAT-1];

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready |=> valid_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> results.valid && !results.ready)
        else $error("input stalled without a waiting result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> $stable(valid_reg))
        else $error("pipeline moved while result stalled");

endmodule

### rtl/core/earot_cell.sv
// ----------------------------------------------------------------------------
// earot_cell
// one cordic micro-rotation for the three angles, point rides along
// ----------------------------------------------------------------------------
module earot_cell
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [earot_pkg::SHIFT_W-1:0] stage,
    input  earot_pkg::cordic_beat_t din,
    output earot_pkg::cordic_beat_t dout
);
    import earot_pkg::*;

    cordic_beat_t beat_reg;
    cordic_beat_t beat_next;
    cval_t        at;

    always_comb
    begin
        beat_next = din;
        at = CW'(atan_value(5'(stage)));
        for (int k = 0; k < 3; k++)
        begin
            if (!din.rot[k].z[CW-1])
            begin
                beat_next.rot[k].x = din.rot[k].x - (din.rot[k].y >>> stage);
                beat_next.rot[k].y = din.rot[k].y + (din.rot[k].x >>> stage);
                beat_next.rot[k].z = din.rot[k].z - at;
            end
            else
            begin
                beat_next.rot[k].x = din.rot[k].x + (din.rot[k].y >>> stage);
                beat_next.rot[k].y = din.rot[k].y - (din.rot[k].x >>> stage);
                beat_next.rot[k].z = din.rot[k].z + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            beat_reg <= beat_next;
    end

    assign dout = beat_reg;

endmodule

### rtl/core/earot_matrix.sv
// ----------------------------------------------------------------------------
// earot_matrix
// builds the rotation matrix from sine / cosine and applies it to the point
// ----------------------------------------------------------------------------
module earot_matrix
(
    input  logic                    clk,
    input  logic                    en,
    input  earot_pkg::cordic_beat_t din,
    output earot_pkg::coord_t       rot_x,
    output earot_pkg::coord_t       rot_y,
    output earot_pkg::coord_t       rot_z,
    output logic                    saturated
);
    import earot_pkg::*;

    localparam logic signed [OUT_W-1:0] V_HI = OUT_W'((1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [OUT_W-1:0] V_LO = OUT_W'(-(1 <<< (COORD_WIDTH - 1)));

    cval_t sf, cf, st, ct, sp, cp;

    cval_t  ctcp_reg, ctsp_reg, sfct_reg, cfct_reg, sfst_reg, cfst_reg;
    cval_t  cfsp_reg, cfcp_reg, sfsp_reg, sfcp_reg, nst_reg, sp_reg, cp_reg;
    coord_t p1_reg [3];
    logic   inv1_reg;

    cval_t  sfstcp_reg, sfstsp_reg, cfstcp_reg, cfstsp_reg;
    cval_t  ctcp2_reg, ctsp2_reg, sfct2_reg, cfct2_reg, nst2_reg;
    cval_t  cfsp2_reg, cfcp2_reg, sfsp2_reg, sfcp2_reg;
    coord_t p2_reg [3];
    logic   inv2_reg;

    entry_t r [3][3];
    entry_t e3_reg [3][3];
    coord_t p3_reg [3];

    logic signed [TERM_W-1:0] t4_reg [3][3];

    coord_t out_reg [3];
    logic   sat_reg;

    logic signed [ACC_W-1:0] acc [3];
    logic signed [OUT_W-1:0] v [3];
    coord_t                  o_next [3];
    logic                    sat_next;

    always_comb
    begin
        sf = din.neg[0] ? -din.rot[0].y : din.rot[0].y;
        cf = din.neg[0] ? -din.rot[0].x : din.rot[0].x;
        st = din.neg[1] ? -din.rot[1].y : din.rot[1].y;
        ct = din.neg[1] ? -din.rot[1].x : din.rot[1].x;
        sp = din.neg[2] ? -din.rot[2].y : din.rot[2].y;
        cp = din.neg[2] ? -din.rot[2].x : din.rot[2].x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctcp_reg  <= mul30(ct, cp);
            ctsp_reg  <= mul30(ct, sp);
            sfct_reg  <= mul30(sf, ct);
            cfct_reg  <= mul30(cf, ct);
            sfst_reg  <= mul30(sf, st);
            cfst_reg  <= mul30(cf, st);
            cfsp_reg  <= mul30(cf, sp);
            cfcp_reg  <= mul30(cf, cp);
            sfsp_reg  <= mul30(sf, sp);
            sfcp_reg  <= mul30(sf, cp);
            nst_reg   <= -st;
            sp_reg    <= sp;
            cp_reg    <= cp;
            p1_reg[0] <= din.cx;
            p1_reg[1] <= din.cy;
            p1_reg[2] <= din.cz;
            inv1_reg  <= din.inv;

            sfstcp_reg <= mul30(sfst_reg, cp_reg);
            sfstsp_reg <= mul30(sfst_reg, sp_reg);
            cfstcp_reg <= mul30(cfst_reg, cp_reg);
            cfstsp_reg <= mul30(cfst_reg, sp_reg);
            ctcp2_reg  <= ctcp_reg;
            ctsp2_reg  <= ctsp_reg;
            sfct2_reg  <= sfct_reg;
            cfct2_reg  <= cfct_reg;
            nst2_reg   <= nst_reg;
            cfsp2_reg  <= cfsp_reg;
            cfcp2_reg  <= cfcp_reg;
            sfsp2_reg  <= sfsp_reg;
            sfcp2_reg  <= sfcp_reg;
            p2_reg     <= p1_reg;
            inv2_reg   <= inv1_reg;
        end
    end

    always_comb
    begin
        r[0][0] = clamp1(ctcp2_reg);
        r[0][1] = clamp1(ctsp2_reg);
        r[0][2] = clamp1(nst2_reg);
        r[1][0] = clamp1(sfstcp_reg - cfsp2_reg);
        r[1][1] = clamp1(sfstsp_reg + cfcp2_reg);
        r[1][2] = clamp1(sfct2_reg);
        r[2][0] = clamp1(cfstcp_reg + sfsp2_reg);
        r[2][1] = clamp1(cfstsp_reg - sfcp2_reg);
        r[2][2] = clamp1(cfct2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    e3_reg[i][j] <= inv2_reg ? r[j][i] : r[i][j];
                    t4_reg[i][j] <= TERM_W'(e3_reg[i][j]) * TERM_W'(p3_reg[j]);
                end
            end
            p3_reg <= p2_reg;
        end
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(t4_reg[i][0]) + ACC_W'(t4_reg[i][1]) + ACC_W'(t4_reg[i][2])
                     + ACC_W'(536870912);
            v[i] = OUT_W'(acc[i] >>> 30);
            o_next[i] = COORD_WIDTH'(v[i]);
            if (v[i] > V_HI)
            begin
                o_next[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                sat_next = 1'b1;
            end
            if (v[i] < V_LO)
            begin
                o_next[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                sat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= o_next;
            sat_reg <= sat_next;
        end
    end

    assign rot_x     = out_reg[0];
    assign rot_y     = out_reg[1];
    assign rot_z     = out_reg[2];
    assign saturated = sat_reg;

endmodule

### tb/earot_tb_checker.sv
// ----------------------------------------------------------------------------
// earot_tb_checker
// predicts the rotated point of every accepted beat and compares results
// ----------------------------------------------------------------------------
// Keeps a private copy of the angle and mode registers, computes sine and
// cosine by its own cordic, builds the z-y-x matrix, and queues the expected
// rotated point at each accepted input beat. Each accepted result beat is
// compared field by field with the oldest queued point.
module earot_tb_checker
    import earot_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    earot_point_if                 points,
    earot_result_if                results,
    output int                     errors,
    output int                     pending,
    output int                     results_seen,
    output int                     clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   sat;
    } rotated_t;

    angle_t   roll_q;
    angle_t   pitch_q;
    angle_t   yaw_q;
    logic     inverse_q;
    rotated_t rotated_q[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shift(a * b + 64'sd536870912, 30);
    endfunction

    function automatic void trig_of(input angle_t a, output longint s, output longint c);
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        t = {a, 16'h0};
        flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
        if (flip)
            t = t + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(t));
        for (int i = 0; i < TRIG_ITERATIONS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_value(5'(i)));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_value(5'(i)));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint unit_clip(longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    function automatic rotated_t rotate_point(coord_t px, coord_t py, coord_t pz);
        longint   sf, cf, st, ct, sp, cp, sfst, cfst, acc, v, e;
        longint   m[3][3];
        longint   p[3];
        longint   o[3];
        longint   hi;
        rotated_t r;
        trig_of(roll_q, sf, cf);
        trig_of(pitch_q, st, ct);
        trig_of(yaw_q, sp, cp);
        sfst = q30_mul(sf, st);
        cfst = q30_mul(cf, st);
        m[0][0] = q30_mul(ct, cp);
        m[0][1] = q30_mul(ct, sp);
        m[0][2] = -st;
        m[1][0] = q30_mul(sfst, cp) - q30_mul(cf, sp);
        m[1][1] = q30_mul(sfst, sp) + q30_mul(cf, cp);
        m[1][2] = q30_mul(sf, ct);
        m[2][0] = q30_mul(cfst, cp) + q30_mul(sf, sp);
        m[2][1] = q30_mul(cfst, sp) - q30_mul(sf, cp);
        m[2][2] = q30_mul(cf, ct);
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                e = inverse_q ? m[j][i] : m[i][j];
                acc = acc + unit_clip(e) * p[j];
            end
            v = floor_shift(acc + 64'sd536870912, 30);
            if (v > hi)
            begin
                v = hi;
                r.sat = 1'b1;
            end
            if (v < -hi - 1)
            begin
                v = -hi - 1;
                r.sat = 1'b1;
            end
            o[i] = v;
        end
        r.x = coord_t'(o[0]);
        r.y = coord_t'(o[1]);
        r.z = coord_t'(o[2]);
        return r;
    endfunction

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rotated_t want;
        if (!rst_n)
        begin
            roll_q       <= '0;
            pitch_q      <= '0;
            yaw_q        <= '0;
            inverse_q    <= 1'b0;
            errors       <= 0;
            results_seen <= 0;
            clipped_seen <= 0;
            rotated_q.delete();
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                results_seen <= results_seen + 1;
                if (results.saturated)
                    clipped_seen <= clipped_seen + 1;
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat x=%0d y=%0d z=%0d sat=%0b", $time,
                             results.rot_x, results.rot_y, results.rot_z, results.saturated);
                    errors <= errors + 1;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (results.rot_x !== want.x || results.rot_y !== want.y
                        || results.rot_z !== want.z || results.saturated !== want.sat)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d sat=%0b", $time,
                                 want.x, want.y, want.z, want.sat);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d sat=%0b", $time,
                                 results.rot_x, results.rot_y, results.rot_z,
                                 results.saturated);
                        errors <= errors + 1;
                    end
                end
            end
            if (points.valid && points.ready)
                rotated_q.push_back(rotate_point(points.coord_x, points.coord_y,
                                                 points.coord_z));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROLL:    roll_q <= cfg_data;
                    REG_PITCH:   pitch_q <= cfg_data;
                    REG_YAW:     yaw_q <= cfg_data;
                    REG_INVERSE: inverse_q <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the euler angle point rotator
// ----------------------------------------------------------------------------
// Runs angle and mode phases, extremes first then random; extreme phases send
// directed and random points, random phases only random points, in bursts
// while the result side stalls on its own pattern. earot_tb_checker checks.
module tb_top;
    import earot_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    results_seen;
    int                    clipped_seen;
    int                    idle_cycles;
    int                    stall_mode;

    earot_point_if  points();
    earot_result_if results();

    euler_angle_point_rotation DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (points.sink),
        .results   (results.source)
    );

    earot_tb_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .points       (points),
        .results      (results),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .clipped_seen (clipped_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stall pattern, mode changes now and then
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       results.ready <= 1'b1;
            1:       results.ready <= ($urandom_range(0, 3) != 0);
            2:       results.ready <= ($urandom_range(0, 1) != 0);
            default: results.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((points.valid && points.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // write enable stays high across consecutive writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_angles(angle_t r, angle_t p, angle_t y, logic inv);
        write_reg(REG_ROLL, r);
        write_reg(REG_PITCH, p);
        write_reg(REG_YAW, y);
        write_reg(REG_INVERSE, {15'd0, inv});
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // one beat; valid stays high across back to back beats
    task automatic send_point(coord_t x, coord_t y, coord_t z);
        points.valid   <= 1'b1;
        points.coord_x <= x;
        points.coord_y <= y;
        points.coord_z <= z;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(int n);
        points.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(0, 5))
            0:       return coord_t'($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
            1:       return coord_t'($signed($urandom_range(0, 8191)) - 4096);
            2:       return coord_t'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic angle_t any_angle();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return angle_t'({$urandom_range(0, 3), 14'h0});
            3:       return angle_t'($signed($urandom_range(0, 64)) - 32);
            default: return angle_t'($urandom);
        endcase
    endfunction

    task automatic random_points(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_point(any_coord(), any_coord(), any_coord());
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 6));
        end
        pause_sender(0);
    endtask

    task automatic directed_points();
        coord_t lim[4];
        lim = '{24'sh7FFFFF, -24'sh800000, 24'sh001000, 24'sh0};
        foreach (lim[i])
            foreach (lim[j])
                send_point(lim[i], lim[j], lim[(i + j) % 4]);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_point(-24'sh800000, -24'sh800000, -24'sh800000);
        send_point(24'sh555555, -24'sh2AAAAB, 24'sh0F0F0F);
        send_point(24'shFFFFFF, 24'sh000001, 24'shAAAAAA);
        pause_sender(2);
    endtask

    initial
    begin
        angle_t extremes[6];
        extremes      = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0001};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        points.valid  = 1'b0;
        points.coord_x = '0;
        points.coord_y = '0;
        points.coord_z = '0;
        results.ready = 1'b0;
        stall_mode    = 0;
        idle_cycles   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: identity rotation
        directed_points();
        drain();

        foreach (extremes[k])
        begin
            set_angles(extremes[k], extremes[(k + 2) % 6], extremes[(k + 4) % 6], k[0]);
            directed_points();
            random_points(30);
            drain();
        end
        for (int ph = 0; ph < 12; ph++)
        begin
            set_angles(any_angle(), any_angle(), any_angle(), $urandom_range(0, 1));
            random_points(100);
            drain();
        end

        $display("covered %0d rotated points (%0d clipped) over 19 angle and mode settings",
                 results_seen, clipped_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
